[sv/ffha_pkg.sv]
// ----------------------------------------------------------------------------
// ffha_pkg: shared types and constants for the first-fit heap allocator
// Request kinds, status codes and the request record passed front to back.
// ----------------------------------------------------------------------------
package ffha_pkg;

	localparam int HEAP_WORDS_DEF = 512;
	localparam int HDR_W = 13;
	localparam int SIZE_W = 12;

	typedef enum logic [0:0] {
		REQ_ALLOC = 1'b0,
		REQ_FREE  = 1'b1
	} req_kind_t;

	typedef enum logic [2:0] {
		ST_OK        = 3'd0,
		ST_ZERO      = 3'd1,
		ST_TOO_LARGE = 3'd2,
		ST_NO_SPACE  = 3'd3,
		ST_OUTSIDE   = 3'd4,
		ST_NOT_START = 3'd5,
		ST_DBL_FREE  = 3'd6
	} status_t;

	// classified request: front decides early rejects, back walks the heap
	typedef struct packed {
		req_kind_t   kind;
		logic        early;     // status already final, no walk
		status_t     status;
		logic [12:0] words;     // rounded size in words (alloc)
		logic [15:0] addr;      // byte offset (free)
	} cmd_t;

	typedef struct packed {
		status_t     status;
		logic [11:0] data_offset;
	} rsp_t;

endpackage

[sv/ffha_front.sv]
// ----------------------------------------------------------------------------
// ffha_front: request intake and classification
// Rounds sizes, rejects zero/too-large/outside requests, queues commands.
// ----------------------------------------------------------------------------
module ffha_front import ffha_pkg::*; #(
	parameter int HEAP_WORDS = HEAP_WORDS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        req_type,
	input  logic [15:0] req_size,
	input  logic [15:0] req_addr,
	output logic        cmd_valid,
	input  logic        cmd_ready,
	output cmd_t        cmd
);
	localparam logic [16:0] MAX_BYTES = 17'((HEAP_WORDS - 1) * 8);
	localparam logic [16:0] HEAP_BYTES = 17'(HEAP_WORDS * 8);

	cmd_t        q_q [2];
	logic        wp_q, rp_q;
	logic [1:0]  cnt_q;
	logic [16:0] rs;
	cmd_t        c;

	always_comb begin
		rs = (17'(req_size) + 17'd7) & ~17'd7;
		c.kind = req_kind_t'(req_type);
		c.words = rs[15:3];
		c.addr = req_addr;
		c.early = 1'b0;
		c.status = ST_OK;
		if (req_type == REQ_FREE) begin
			if (17'(req_addr) >= HEAP_BYTES) begin
				c.early = 1'b1;
				c.status = ST_OUTSIDE;
			end
		end else if (req_size == 16'd0) begin
			c.early = 1'b1;
			c.status = ST_ZERO;
		end else if (rs > MAX_BYTES) begin
			c.early = 1'b1;
			c.status = ST_TOO_LARGE;
		end
	end

	assign in_ready = (cnt_q != 2'd2);
	assign cmd_valid = (cnt_q != 2'd0);
	assign cmd = q_q[rp_q];

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) q_q[wp_q] <= c;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0;
			rp_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (in_valid && in_ready) wp_q <= ~wp_q;
			if (cmd_valid && cmd_ready) rp_q <= ~rp_q;
			cnt_q <= cnt_q + 2'(in_valid && in_ready) - 2'(cmd_valid && cmd_ready);
		end
	end
endmodule

[sv/ffha_back.sv]
// ----------------------------------------------------------------------------
// ffha_back: heap walker
// Walks the header memory for allocate, free and merge; one header per read.
// ----------------------------------------------------------------------------
module ffha_back import ffha_pkg::*; #(
	parameter int HEAP_WORDS = HEAP_WORDS_DEF
) (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  cmd_valid,
	output logic  cmd_ready,
	input  cmd_t  cmd,
	output logic  rsp_valid,
	input  logic  rsp_ready,
	output rsp_t  rsp
);
	localparam int AW = $clog2(HEAP_WORDS);
	localparam int WW = AW + 2;     // walk pointer, room past the end
	localparam logic [WW-1:0] HW = WW'(HEAP_WORDS);

	typedef enum logic [10:0] {
		S_CLEAR = 11'b00000000001,
		S_IDLE  = 11'b00000000010,
		S_RD    = 11'b00000000100,
		S_WAIT  = 11'b00000001000,
		S_EVAL  = 11'b00000010000,
		S_WR2   = 11'b00000100000,
		S_MRD   = 11'b00001000000,
		S_MWAIT = 11'b00010000000,
		S_MEVAL = 11'b00100000000,
		S_MNWT  = 11'b01000000000,
		S_OUT   = 11'b10000000000
	} state_t;

	state_t state_q;
	logic [HDR_W-1:0] mem [HEAP_WORDS];
	logic [HDR_W-1:0] rd_q;
	logic [AW-1:0]    ra;
	logic             we;
	logic [AW-1:0]    wa;
	logic [HDR_W-1:0] wd;
	logic [AW:0]      clr_q;
	cmd_t             c_q;
	logic [WW-1:0]    w_q, n_q;
	logic [SIZE_W-1:0] wsz_q;
	logic             wocc_q;
	logic             started_q;
	logic [AW-1:0]    a2_q;
	logic [HDR_W-1:0] d2_q;
	status_t          st_q;
	logic [11:0]      off_q;
	logic [WW-1:0]    nxt;
	logic [WW-1:0]    need;
	logic [15:0]      fw;

	assign nxt  = w_q + WW'(1) + WW'(rd_q[SIZE_W-1:0]);
	assign need = WW'(c_q.words) + WW'(2);
	assign fw   = (16'(w_q[AW-1:0]) + 16'd1) << 3;

	always_ff @(posedge clk) begin
		if (we) mem[wa] <= wd;
		rd_q <= mem[ra];
	end

	assign cmd_ready = (state_q == S_IDLE);
	assign rsp_valid = (state_q == S_OUT);
	assign rsp.status = st_q;
	assign rsp.data_offset = off_q;

	always_comb begin
		ra = w_q[AW-1:0];
		// fetch the next header while header w is evaluated
		if (state_q == S_MEVAL) ra = nxt[AW-1:0];
		we = 1'b0;
		wa = w_q[AW-1:0];
		wd = '0;
		unique case (state_q)
			S_CLEAR: begin
				we = 1'b1;
				wa = clr_q[AW-1:0];
			end
			S_IDLE, S_RD, S_WAIT, S_MRD, S_MWAIT, S_MNWT, S_OUT: ;
			S_EVAL: begin
				if (c_q.kind == REQ_ALLOC) begin
					if (!started_q) begin
						we = 1'b1;
						wa = '0;
						if (need < HW) wd = {1'b1, SIZE_W'(c_q.words)};
						else wd = {1'b1, SIZE_W'(HEAP_WORDS - 1)};
					end else if (!rd_q[SIZE_W] && WW'(rd_q[SIZE_W-1:0]) >= need) begin
						we = 1'b1;
						wd = {1'b1, SIZE_W'(c_q.words)};
					end
				end else if (fw == c_q.addr && rd_q[SIZE_W]) begin
					we = 1'b1;
					wd = {1'b0, rd_q[SIZE_W-1:0]};
				end
			end
			S_WR2: begin
				we = 1'b1;
				wa = a2_q;
				wd = d2_q;
			end
			S_MEVAL: ;
			default: ;
		endcase
		if (state_q == S_MNWT && !wocc_q && !rd_q[SIZE_W]) begin
			we = 1'b1;
			wd = {1'b0, SIZE_W'(wsz_q + 12'd1 + rd_q[SIZE_W-1:0])};
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: if (cmd_valid) c_q <= cmd;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			clr_q <= '0;
			w_q <= '0;
			n_q <= '0;
			wsz_q <= '0;
			wocc_q <= 1'b0;
			started_q <= 1'b0;
			a2_q <= '0;
			d2_q <= '0;
			st_q <= ST_OK;
			off_q <= '0;
		end else begin
			unique case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + (AW+1)'(1);
					if (clr_q == (AW+1)'(HEAP_WORDS - 1)) state_q <= S_IDLE;
				end
				S_IDLE: if (cmd_valid) begin
					w_q <= '0;
					off_q <= '0;
					st_q <= cmd.status;
					if (cmd.early) state_q <= S_OUT;
					else if (cmd.kind == REQ_FREE && !started_q) begin
						st_q <= ST_NOT_START;
						state_q <= S_OUT;
					end else state_q <= S_RD;
				end
				S_RD: state_q <= S_WAIT;
				S_WAIT: state_q <= S_EVAL;
				S_EVAL: begin
					if (c_q.kind == REQ_ALLOC) begin
						if (!started_q) begin
							started_q <= 1'b1;
							st_q <= ST_OK;
							off_q <= 12'd8;
							a2_q <= AW'(c_q.words + 13'd1);
							d2_q <= {1'b0, SIZE_W'(13'(HEAP_WORDS - 2) - c_q.words)};
							state_q <= (need < HW) ? S_WR2 : S_OUT;
						end else if (!rd_q[SIZE_W] && WW'(rd_q[SIZE_W-1:0]) >= need) begin
							st_q <= ST_OK;
							off_q <= fw[11:0];
							a2_q <= AW'(w_q + WW'(1) + WW'(c_q.words));
							d2_q <= {1'b0, SIZE_W'(rd_q[SIZE_W-1:0] - 12'd1
								- SIZE_W'(c_q.words))};
							state_q <= S_WR2;
						end else if (nxt >= HW) begin
							st_q <= ST_NO_SPACE;
							state_q <= S_OUT;
						end else begin
							w_q <= nxt;
							state_q <= S_RD;
						end
					end else begin
						if (fw == c_q.addr) begin
							st_q <= rd_q[SIZE_W] ? ST_OK : ST_DBL_FREE;
							w_q <= '0;
							state_q <= S_MRD;
						end else if (nxt >= HW) begin
							st_q <= ST_NOT_START;
							state_q <= S_OUT;
						end else begin
							w_q <= nxt;
							state_q <= S_RD;
						end
					end
				end
				S_WR2: state_q <= S_OUT;
				S_MRD: state_q <= S_MWAIT;
				S_MWAIT: state_q <= S_MEVAL;
				S_MEVAL: begin
					wsz_q <= rd_q[SIZE_W-1:0];
					wocc_q <= rd_q[SIZE_W];
					n_q <= nxt;
					if (w_q == '0 && WW'(rd_q[SIZE_W-1:0]) >= HW - WW'(1)) state_q <= S_OUT;
					else if (nxt >= HW) state_q <= S_OUT;
					else state_q <= S_MNWT;
				end
				S_MNWT: begin
					// rd_q now holds header n; merge and reread w, or step on
					if (!(!wocc_q && !rd_q[SIZE_W])) w_q <= n_q;
					state_q <= S_MRD;
				end
				S_OUT: if (rsp_ready) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule

[sv/first_fit_heap_allocator_top.sv]
// ----------------------------------------------------------------------------
// first_fit_heap_allocator_top: first-fit allocator over an implicit header list
// ----------------------------------------------------------------------------
// Requests enter on s_axis (tuser = kind: 0 allocate, 1 free; tdata = size,
// addr). One response per request leaves on m_axis (tdata = status,
// data_offset). A two-entry queue decouples intake from the heap walker, so
// up to two requests are taken while the walker is busy.
// Requests answered without a walk (zero size, too large, outside heap, free
// before any allocate) go from the queue straight to the response when the
// walker is idle. An allocate walks headers, one read, wait and evaluate step
// per block visited; a free walks to its block the same way and then runs a
// merge walk with an extra wait for the next header in each step. The header
// memory's one read port sets the pace of both walks.
// After reset the header memory is cleared, one entry per cycle, over all
// HEAP_WORDS entries; the queue takes up to two requests meanwhile.
// A stalled m_axis holds the response; the walker waits and the queue fills.
// ----------------------------------------------------------------------------
module first_fit_heap_allocator_top import ffha_pkg::*; #(
	parameter int HEAP_WORDS = HEAP_WORDS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [31:0] s_axis_tdata,   // [15:0] req_size, [31:16] req_addr
	input  logic        s_axis_tuser,   // [0] req_type
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [15:0] m_axis_tdata    // [2:0] status, [14:3] data_offset, pad
);
	logic cmd_valid, cmd_ready;
	cmd_t cmd;
	rsp_t rsp;

	ffha_front #(.HEAP_WORDS(HEAP_WORDS)) u_front (
		.clk(clk), .arst_n(arst_n),
		.in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
		.req_type(s_axis_tuser), .req_size(s_axis_tdata[15:0]),
		.req_addr(s_axis_tdata[31:16]),
		.cmd_valid(cmd_valid), .cmd_ready(cmd_ready), .cmd(cmd)
	);

	ffha_back #(.HEAP_WORDS(HEAP_WORDS)) u_back (
		.clk(clk), .arst_n(arst_n),
		.cmd_valid(cmd_valid), .cmd_ready(cmd_ready), .cmd(cmd),
		.rsp_valid(m_axis_tvalid), .rsp_ready(m_axis_tready), .rsp(rsp)
	);

	assign m_axis_tdata = {1'b0, rsp.data_offset, rsp.status};
endmodule

[verif/ffha_checker.sv]
// ----------------------------------------------------------------------------
// ffha_checker: response checker for the first-fit heap allocator
// Keeps its own header list, computes the response for every accepted
// request and compares it with what the block returns, in order.
// ----------------------------------------------------------------------------
module ffha_checker import ffha_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	input  logic        s_axis_tready,
	input  logic [31:0] s_axis_tdata,
	input  logic        s_axis_tuser,
	input  logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	input  logic [15:0] m_axis_tdata,
	output int          err_cnt,
	output int          pending
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int NW = HEAP_WORDS_DEF;

	logic [12:0] hdr_q [NW];
	rsp_t        rsp_expected_q [$];

	function automatic int hsize(int w);
		return (w < NW) ? int'(hdr_q[w][11:0]) : 0;
	endfunction

	function automatic bit hocc(int w);
		return (w < NW) ? hdr_q[w][12] : 1'b0;
	endfunction

	function automatic void hset(int w, int sz, bit occ);
		if (w < NW) hdr_q[w] = {occ, sz[11:0]};
	endfunction

	function automatic void coalesce();
		int w;
		int n;
		int guard;
		w = 0;
		guard = 0;
		if (hsize(0) >= NW - 1) return;
		while (w < NW && guard < 2 * NW) begin
			n = w + 1 + hsize(w);
			guard++;
			if (n >= NW) break;
			if (!hocc(w) && !hocc(n)) begin
				hset(w, hsize(w) + 1 + hsize(n), 1'b0);
				continue;
			end
			w = n;
		end
	endfunction

	function automatic rsp_t predict_alloc(int req);
		rsp_t r;
		int rs;
		int rw;
		int w;
		int sz;
		r = '{status: ST_OK, data_offset: '0};
		if (req == 0) begin
			r.status = ST_ZERO;
			return r;
		end
		rs = (req + 7) & ~7;
		if (rs > NW * 8 - 8) begin
			r.status = ST_TOO_LARGE;
			return r;
		end
		rw = rs / 8;
		if (hsize(0) == 0) begin
			if (rw + 2 < NW) begin
				hset(0, rw, 1'b1);
				hset(1 + rw, NW - 2 - rw, 1'b0);
			end else begin
				hset(0, NW - 1, 1'b1);
			end
			r.data_offset = 12'd8;
			return r;
		end
		w = 0;
		while (w < NW) begin
			sz = hsize(w);
			if (!hocc(w) && sz >= rw + 2) begin
				hset(w, rw, 1'b1);
				hset(w + 1 + rw, sz - 1 - rw, 1'b0);
				r.data_offset = 12'((w + 1) * 8);
				return r;
			end
			w += 1 + sz;
		end
		r.status = ST_NO_SPACE;
		return r;
	endfunction

	function automatic rsp_t predict_free(int addr);
		rsp_t r;
		int w;
		r = '{status: ST_NOT_START, data_offset: '0};
		if (addr >= NW * 8) begin
			r.status = ST_OUTSIDE;
			return r;
		end
		if (hsize(0) == 0) return r;
		w = 0;
		while (w < NW) begin
			if ((w + 1) * 8 == addr) begin
				if (hocc(w)) begin
					hset(w, hsize(w), 1'b0);
					r.status = ST_OK;
				end else begin
					r.status = ST_DBL_FREE;
				end
				coalesce();
				return r;
			end
			w += 1 + hsize(w);
		end
		return r;
	endfunction

	assign pending = rsp_expected_q.size();

	always @(posedge clk or negedge arst_n) begin
		rsp_t got;
		rsp_t want;
		if (!arst_n) begin
			foreach (hdr_q[i]) hdr_q[i] = '0;
			rsp_expected_q.delete();
			err_cnt <= 0;
		end else begin
			if (s_axis_tvalid && s_axis_tready) begin
				if (req_kind_t'(s_axis_tuser) == REQ_ALLOC)
					rsp_expected_q.push_back(predict_alloc(int'(s_axis_tdata[15:0])));
				else
					rsp_expected_q.push_back(predict_free(int'(s_axis_tdata[31:16])));
			end
			if (m_axis_tvalid && m_axis_tready) begin
				got = '{status: status_t'(m_axis_tdata[2:0]), data_offset: m_axis_tdata[14:3]};
				if (rsp_expected_q.size() == 0) begin
					$display("%0t: unexpected response status=%0d offset=%0d",
						$realtime, got.status, got.data_offset);
					err_cnt <= err_cnt + 1;
				end else begin
					want = rsp_expected_q.pop_front();
					if (got.status !== want.status || got.data_offset !== want.data_offset) begin
						$display("%0t: mismatch expected status=%0d offset=%0d, got status=%0d offset=%0d",
							$realtime, want.status, want.data_offset, got.status, got.data_offset);
						err_cnt <= err_cnt + 1;
					end
				end
			end
		end
	end

endmodule

[verif/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top: testbench for first_fit_heap_allocator_top
// Drives directed and random allocate/free requests under several
// backpressure mixes; ffha_checker predicts and compares every response.
// ----------------------------------------------------------------------------
module tb_top import ffha_pkg::*;;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int N_RANDOM = 515;
	localparam int CYCLE_LIMIT = 10_000_000;

	logic        clk;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [31:0] s_axis_tdata;
	logic        s_axis_tuser;
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [15:0] m_axis_tdata;
	int          err_cnt;
	int          pending;
	int          cycles = 0;
	int          idle_pct;
	int          stall_pct;
	logic        s_fire;
	logic [15:0] live_offsets [$];

	first_fit_heap_allocator_top i_dut (.*);

	ffha_checker i_checker (.*);

	always begin
		clk = 1'b1; #5;
		clk = 1'b0; #5;
	end

	always @(posedge clk) begin
		s_fire <= s_axis_tvalid && s_axis_tready;
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("tb_top NOT OK");
			$finish;
		end
		// successful allocations feed the free stimulus
		if (m_axis_tvalid && m_axis_tready && m_axis_tdata[2:0] == ST_OK
				&& m_axis_tdata[14:3] != 0)
			live_offsets.push_back({4'd0, m_axis_tdata[14:3]});
	end

	always @(negedge clk)
		m_axis_tready <= ($urandom_range(99) >= stall_pct);

	task automatic send_req(req_kind_t kind, logic [15:0] size, logic [15:0] addr);
		while ($urandom_range(99) < idle_pct) begin
			s_axis_tvalid = 1'b0;
			@(negedge clk);
		end
		s_axis_tvalid = 1'b1;
		s_axis_tuser  = kind;
		s_axis_tdata  = {addr, size};
		do @(negedge clk); while (!s_fire);
	endtask

	task automatic drain();
		s_axis_tvalid = 1'b0;
		while (pending != 0) @(negedge clk);
	endtask

	initial begin
		int k;
		int sel;
		logic [15:0] sz;
		logic [15:0] ad;
		idle_pct = 0;
		stall_pct = 0;
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		s_axis_tuser = REQ_ALLOC;
		repeat (3) @(negedge clk);
		arst_n = 1'b1;

		// directed: rejects, heap not started, whole-heap block, double free
		send_req(REQ_FREE, 16'd0, 16'd8);
		send_req(REQ_ALLOC, 16'd0, 16'hFFFF);
		send_req(REQ_ALLOC, 16'hFFFF, 16'd0);
		send_req(REQ_ALLOC, 16'd4089, 16'd0);
		send_req(REQ_FREE, 16'hFFFF, 16'd4096);
		send_req(REQ_FREE, 16'd0, 16'hFFFF);
		send_req(REQ_ALLOC, 16'd4080, 16'd0);   // 8 leftover bytes absorbed
		send_req(REQ_ALLOC, 16'd1, 16'd0);
		send_req(REQ_FREE, 16'd0, 16'd8);
		send_req(REQ_FREE, 16'd0, 16'd8);
		send_req(REQ_FREE, 16'd0, 16'd12);
		send_req(REQ_ALLOC, 16'd1, 16'd0);
		send_req(REQ_ALLOC, 16'd4088, 16'd0);
		send_req(REQ_FREE, 16'd0, 16'd16);
		send_req(REQ_FREE, 16'd0, 16'd24);
		send_req(REQ_ALLOC, 16'd4072, 16'd0);
		send_req(REQ_ALLOC, 16'd8, 16'd0);
		send_req(REQ_FREE, 16'd0, 16'd4095);
		send_req(REQ_FREE, 16'd0, 16'd8);
		send_req(REQ_ALLOC, 16'd4088, 16'd0);
		send_req(REQ_FREE, 16'd0, 16'd8);
		send_req(REQ_ALLOC, 16'd9, 16'd0);
		send_req(REQ_ALLOC, 16'd16, 16'd0);
		send_req(REQ_FREE, 16'd0, 16'd8);
		send_req(REQ_ALLOC, 16'd8, 16'd0);
		drain();   // hold off until the block has answered everything

		for (int i = 0; i < N_RANDOM; i++) begin
			if (i % (N_RANDOM / 4) == 0) begin
				case (i / (N_RANDOM / 4))
					0: begin idle_pct = 0;  stall_pct = 0;  end
					1: begin idle_pct = 54; stall_pct = 0;  end
					2: begin idle_pct = 0;  stall_pct = 54; end
					default: begin idle_pct = 21; stall_pct = 21; end
				endcase
			end
			sel = $urandom_range(99);
			ad = 16'($urandom);
			sz = 16'($urandom);
			if (sel < 55) begin
				k = $urandom_range(99);
				if (k < 80) sz = 16'($urandom_range(96, 1));
				else if (k < 90) sz = 16'($urandom_range(4095, 97));
				else if (k < 95) sz = 16'd0;
				send_req(REQ_ALLOC, sz, ad);
			end else begin
				k = $urandom_range(99);
				if (k < 75 && live_offsets.size() != 0) begin
					sel = $urandom_range(live_offsets.size() - 1);
					ad = live_offsets[sel];
					if ($urandom_range(1)) live_offsets.delete(sel);
				end else if (k < 90) begin
					ad = 16'($urandom_range(4095));
				end
				send_req(REQ_FREE, sz, ad);
			end
		end
		drain();
		repeat (4000) @(negedge clk);
		if (err_cnt == 0 && pending == 0)
			$display("tb_top OK");
		else
			$display("tb_top NOT OK");
		$finish;
	end

endmodule
